[rtl/sclf_pkg.sv]
// ----------------------------------------------------------------------------
// sclf_pkg
// Shared types and constants for the serial command line framer.
// ----------------------------------------------------------------------------
package sclf_pkg;

    // Default size of the line store, in characters.
    localparam int LINE_MAX_DEF = 32;

    // Width of the line limit register and its value after reset.
    localparam int         CFG_W       = 6;
    localparam logic [5:0] LIMIT_RESET = 6'd32;

    // Width of the drop counter, which saturates at its all-ones value.
    localparam int CNT_W = 16;

    // Characters the framer recognises.
    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_S   = 8'h53;
    localparam logic [7:0] CHAR_Y   = 8'h59;
    localparam logic [7:0] CHAR_N   = 8'h4E;
    localparam logic [7:0] CHAR_US  = 8'h5F;

    // A sync line is exactly this long.
    localparam int SYNC_LEN = 6;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_CMD   = 2'd0,
        KIND_SYNC  = 2'd1,
        KIND_EMPTY = 2'd2,
        KIND_OVER  = 2'd3
    } kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_byte;   // store or drop the accepted character
        logic start_run;   // newline seen: set up a character run
        logic fetch;       // read the next stored character
        logic put_char;    // load a run character into the output register
        logic put_single;  // load an empty-line or overflow report
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_ignore;   // input byte is NUL or carriage return
        logic in_newline;  // input byte is newline
        logic discarding;  // current line has overflowed
        logic line_empty;  // no characters stored
        logic run_last;    // current run character is the final one
        logic slot_free;   // output register can take a result this cycle
    } status_t;

    // Expected character at each of the first four places of a sync line.
    function automatic logic [7:0] sync_char(input logic [1:0] pos);
        logic [7:0] ch;
        case (pos)
            2'd0:    ch = CHAR_S;
            2'd1:    ch = CHAR_Y;
            2'd2:    ch = CHAR_N;
            default: ch = CHAR_US;
        endcase
        return ch;
    endfunction

endpackage

[rtl/sclf_ctrl.sv]
// ----------------------------------------------------------------------------
// sclf_ctrl
// Controller of the framer: accepts bytes and sequences the results of a line.
// ----------------------------------------------------------------------------
module sclf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  sclf_pkg::status_t status,
    output sclf_pkg::cmd_t    cmd
);
    import sclf_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SINGLE,
        ST_FETCH,
        ST_PUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Bytes are taken only while no line result is being produced.
    assign s_tready = (state_reg == ST_IDLE);

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && !status.in_ignore)
                begin
                    if (!status.in_newline)
                    begin
                        cmd.take_byte = 1'b1;
                    end
                    else if (status.discarding || status.line_empty)
                    begin
                        state_next = ST_SINGLE;
                    end
                    else
                    begin
                        cmd.start_run = 1'b1;
                        state_next    = ST_FETCH;
                    end
                end
            end
            ST_SINGLE:
            begin
                if (status.slot_free)
                begin
                    cmd.put_single = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_PUT;
            end
            ST_PUT:
            begin
                if (status.slot_free)
                begin
                    cmd.put_char = 1'b1;
                    state_next   = status.run_last ? ST_IDLE : ST_FETCH;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/sclf_dp.sv]
// ----------------------------------------------------------------------------
// sclf_dp
// Datapath of the framer: line store, counters, limit register and output
// register.
// ----------------------------------------------------------------------------
module sclf_dp #(
    parameter int LINE_MAX = sclf_pkg::LINE_MAX_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [sclf_pkg::CFG_W-1:0] cfg_wdata,
    input  logic [7:0]                 rx_byte,
    input  logic                       m_tready,
    output logic                       m_tvalid,
    output logic [7:0]                 out_char,
    output logic [sclf_pkg::CNT_W-1:0] out_count,
    output logic [1:0]                 out_kind,
    output logic                       out_last,
    input  sclf_pkg::cmd_t             cmd,
    output sclf_pkg::status_t          status
);
    import sclf_pkg::*;

    localparam int LEN_W = $clog2(LINE_MAX + 1);
    localparam int IDX_W = $clog2(LINE_MAX);
    localparam int CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;

    localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(LINE_MAX);
    localparam logic [LEN_W-1:0] LEN_SYNC = LEN_W'(SYNC_LEN);
    localparam logic [LEN_W-1:0] LEN_ONE  = LEN_W'(1);
    localparam logic [CNT_W-1:0] CNT_FULL = {CNT_W{1'b1}};

    logic [7:0] line_mem [LINE_MAX];

    logic [CFG_W-1:0] limit_reg;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] idx_reg;
    logic             discarding_reg;
    logic [CNT_W-1:0] dropped_reg;
    logic             prefix_ok_reg;
    kind_t            run_kind_reg;
    logic [7:0]       rd_data_reg;
    logic             m_tvalid_reg;
    logic [7:0]       char_reg;
    logic [CNT_W-1:0] count_reg;
    kind_t            kind_reg;
    logic             last_reg;

    logic room;
    logic store_en;
    logic sync_line;
    logic run_last;

    // A character fits while below both the configured limit and the store size.
    assign room = (CMP_W'(len_reg) < CMP_W'(limit_reg)) && (len_reg < LEN_MAX);
    assign store_en  = cmd.take_byte && !discarding_reg && room;
    assign sync_line = (len_reg == LEN_SYNC) && prefix_ok_reg;
    assign run_last  = (LEN_W'(idx_reg + LEN_ONE) == len_reg);

    // Status towards the controller.
    always_comb
    begin
        status.in_ignore  = (rx_byte == CHAR_NUL) || (rx_byte == CHAR_CR);
        status.in_newline = (rx_byte == CHAR_LF);
        status.discarding = discarding_reg;
        status.line_empty = (len_reg == '0);
        status.run_last   = run_last;
        status.slot_free  = !m_tvalid_reg || m_tready;
    end

    // Line store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            line_mem[len_reg[IDX_W-1:0]] <= rx_byte;
        end
        if (cmd.fetch)
        begin
            rd_data_reg <= line_mem[idx_reg[IDX_W-1:0]];
        end
    end

    // Line state, drop counter and limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg      <= LIMIT_RESET;
            len_reg        <= '0;
            idx_reg        <= '0;
            discarding_reg <= 1'b0;
            dropped_reg    <= '0;
            prefix_ok_reg  <= 1'b0;
            run_kind_reg   <= KIND_CMD;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (cmd.take_byte)
            begin
                if (discarding_reg)
                begin
                    if (dropped_reg != CNT_FULL)
                    begin
                        dropped_reg <= dropped_reg + 1'b1;
                    end
                end
                else if (room)
                begin
                    len_reg <= len_reg + LEN_ONE;
                    // Track whether the line so far starts with the sync prefix.
                    if (len_reg == '0)
                    begin
                        prefix_ok_reg <= (rx_byte == sync_char(2'd0));
                    end
                    else if (len_reg < LEN_W'(4))
                    begin
                        prefix_ok_reg <= prefix_ok_reg &&
                                         (rx_byte == sync_char(len_reg[1:0]));
                    end
                end
                else
                begin
                    discarding_reg <= 1'b1;
                    dropped_reg    <= CNT_W'(1);
                end
            end
            if (cmd.start_run)
            begin
                idx_reg      <= '0;
                run_kind_reg <= sync_line ? KIND_SYNC : KIND_CMD;
            end
            if (cmd.put_char)
            begin
                idx_reg <= idx_reg + LEN_ONE;
                if (run_last)
                begin
                    len_reg <= '0;
                end
            end
            if (cmd.put_single)
            begin
                discarding_reg <= 1'b0;
                dropped_reg    <= '0;
                len_reg        <= '0;
            end
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.put_char || cmd.put_single)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (cmd.put_char)
        begin
            kind_reg  <= run_kind_reg;
            char_reg  <= rd_data_reg;
            count_reg <= CNT_W'(len_reg);
            last_reg  <= run_last;
        end
        else if (cmd.put_single)
        begin
            kind_reg  <= discarding_reg ? KIND_OVER : KIND_EMPTY;
            char_reg  <= '0;
            count_reg <= discarding_reg ? dropped_reg : '0;
            last_reg  <= 1'b1;
        end
    end

    assign m_tvalid  = m_tvalid_reg;
    assign out_char  = char_reg;
    assign out_count = count_reg;
    assign out_kind  = kind_reg;
    assign out_last  = last_reg;

endmodule

[rtl/serial_command_line_framer.sv]
// ----------------------------------------------------------------------------
// serial_command_line_framer
// Frames received serial bytes into newline-terminated command lines.
// ----------------------------------------------------------------------------
// Bytes arrive on the slave stream and NUL and carriage return are ignored.
// Other characters are stored up to the line limit (cfg_wdata, at most
// LINE_MAX); further characters are counted and dropped until the newline,
// the count saturating at 65535. A newline gives an overflow report, a sync
// echo of a six-character line starting "SYN_", an empty-line error, or the
// stored command as a run of characters, with tlast on the final transfer.
// An ordinary character leaves the controller idle, so such bytes may be
// transferred back to back. After a newline the input is held off while its
// results are produced: a report is loaded in ST_SINGLE, and a run passes
// through ST_FETCH and ST_PUT for each character, as the line store's read
// port is registered; both wait while the master side stalls. The output
// register lets the next byte be taken while a line's final result still waits.
module serial_command_line_framer #(
    parameter int LINE_MAX = sclf_pkg::LINE_MAX_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [sclf_pkg::CFG_W-1:0] cfg_wdata,  // line limit
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,    // [7:0] rx_byte
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [23:0]                m_tdata,    // [7:0] out_char, [23:8] count
    output logic [1:0]                 m_tuser,    // [1:0] kind
    output logic                       m_tlast     // last
);
    import sclf_pkg::*;

    cmd_t             cmd;
    status_t          status;
    logic [7:0]       out_char;
    logic [CNT_W-1:0] out_count;

    // Controller.
    sclf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath.
    sclf_dp #(
        .LINE_MAX (LINE_MAX)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rx_byte   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .out_char  (out_char),
        .out_count (out_count),
        .out_kind  (m_tuser),
        .out_last  (m_tlast),
        .cmd       (cmd),
        .status    (status)
    );

    // Pack the result fields, first field lowest.
    assign m_tdata = {out_count, out_char};

endmodule

[dv/line_framer_checker.sv]
// ----------------------------------------------------------------------------
// line_framer_checker
// Watches both streams and the limit register of the command line framer,
// tracks the line being assembled, and compares every output transfer with
// the result that the accepted bytes call for.
// ----------------------------------------------------------------------------
module line_framer_checker #(
    parameter int LINE_MAX = sclf_pkg::LINE_MAX_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [sclf_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [7:0]                 s_tdata,
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [23:0]                m_tdata,
    input  logic [1:0]                 m_tuser,
    input  logic                       m_tlast,
    output int                         errors,
    output int                         pending
);

    timeunit 1ns;
    timeprecision 1ps;

    import sclf_pkg::*;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  ch;
        logic [15:0] count;
        logic        last;
    } framer_result_t;

    // Shadow copy of the framer state.
    logic [7:0]       stored [LINE_MAX];
    int               line_len;
    logic             discarding;
    logic [15:0]      dropped;
    logic [CFG_W-1:0] line_limit;

    // Results still owed by the framer, oldest first.
    framer_result_t   results_due [$];
    framer_result_t   seen;

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        errors++;
    endtask

    task automatic queue_result(input kind_t k, input logic [7:0] c,
                                input logic [15:0] n, input logic l);
        framer_result_t r;
        r.kind  = k;
        r.ch    = c;
        r.count = n;
        r.last  = l;
        results_due.push_back(r);
    endtask

    // Updates the line state for one accepted byte and queues the results
    // that a newline releases.
    task automatic absorb_byte(input logic [7:0] b);
        int room;
        int i;
        room = (line_limit > LINE_MAX) ? LINE_MAX : int'(line_limit);
        if (b == CHAR_NUL || b == CHAR_CR)
            return;

        // Ordinary character: store it, or count it once the line is full.
        if (b != CHAR_LF)
        begin
            if (discarding)
            begin
                if (dropped != 16'hFFFF)
                    dropped++;
            end
            else if (line_len < room)
            begin
                stored[line_len] = b;
                line_len++;
            end
            else
            begin
                discarding = 1'b1;
                dropped    = 16'd1;
            end
            return;
        end

        // Newline: overflow report, sync echo, empty-line error or command.
        if (discarding)
        begin
            queue_result(KIND_OVER, 8'h00, dropped, 1'b1);
            discarding = 1'b0;
            dropped    = '0;
            line_len   = 0;
        end
        else if (line_len == SYNC_LEN && stored[0] == CHAR_S && stored[1] == CHAR_Y &&
                 stored[2] == CHAR_N && stored[3] == CHAR_US)
        begin
            for (i = 0; i < SYNC_LEN; i++)
                queue_result(KIND_SYNC, stored[i], 16'(SYNC_LEN), i == SYNC_LEN - 1);
            line_len = 0;
        end
        else if (line_len == 0)
        begin
            queue_result(KIND_EMPTY, 8'h00, 16'd0, 1'b1);
        end
        else
        begin
            for (i = 0; i < line_len; i++)
                queue_result(KIND_CMD, stored[i], 16'(line_len), i == line_len - 1);
            line_len = 0;
        end
    endtask

    // Compares one output transfer with the oldest expectation, field by field.
    task automatic check_result(input framer_result_t got);
        framer_result_t want;
        if (results_due.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result kind %0d char %02h count %0d last %0b",
                                      got.kind, got.ch, got.count, got.last));
            return;
        end
        want = results_due.pop_front();
        if (got.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
        if (got.ch !== want.ch)
            report_mismatch($sformatf("out_char %02h, expected %02h", got.ch, want.ch));
        if (got.count !== want.count)
            report_mismatch($sformatf("count %0d, expected %0d", got.count, want.count));
        if (got.last !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
    endtask

    // Outputs are checked before the input byte of the same edge is taken in,
    // since a newline's results can never leave on the edge that accepts it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_len   = 0;
            discarding = 1'b0;
            dropped    = '0;
            line_limit = LIMIT_RESET;
            errors     = 0;
            results_due.delete();
            pending   <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen.kind  = kind_t'(m_tuser);
                seen.ch    = m_tdata[7:0];
                seen.count = m_tdata[23:8];
                seen.last  = m_tlast;
                check_result(seen);
            end
            if (cfg_we)
                line_limit = cfg_wdata;
            if (s_tvalid && s_tready)
                absorb_byte(s_tdata);
            pending <= results_due.size();
        end
    end

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the serial command line framer: directed lines for the special
// cases, then random lines over several line limits with random idling on
// both streams, a long output stall and an overflowing line sent back to back.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import sclf_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 300;
    localparam int ITEMS_PHASE  = 17;
    localparam int SETTLE_TICKS = 8;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata   = 8'h00;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [23:0]      m_tdata;
    logic [1:0]       m_tuser;
    logic             m_tlast;

    int               errors;
    int               pending;
    int               cycle_count = 0;
    int               items_sent  = 0;
    int               room        = LINE_MAX_DEF;
    logic             src_idle    = 1'b1;
    logic             sink_idle   = 1'b1;
    logic             sink_hold   = 1'b0;
    int               sink_gap    = 0;
    int               gap_draw;
    event             hold_go;

    logic [7:0]       sync_head [4] = '{CHAR_S, CHAR_Y, CHAR_N, CHAR_US};

    serial_command_line_framer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    line_framer_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 0;
    end

    // Output side: a random pause after each transfer, forced low while held.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            sink_gap <= 0;
        end
        else if (sink_hold)
            m_tready <= 1'b0;
        else if (m_tvalid && m_tready)
        begin
            gap_draw = sink_idle ? $urandom_range(0, 10) : 0;
            m_tready <= (gap_draw == 0);
            sink_gap <= (gap_draw == 0) ? 0 : gap_draw - 1;
        end
        else if (!m_tready)
        begin
            if (sink_gap == 0)
                m_tready <= 1'b1;
            else
                sink_gap <= sink_gap - 1;
        end
    end

    // Long stall of the output side, counted here on request.
    initial
    begin
        forever
        begin
            @(hold_go);
            sink_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            sink_hold <= 1'b0;
        end
    end

    // Run limit.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** serial_command_line_framer: FAILED **");
        $finish;
    end

    function automatic logic [7:0] pick_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CHAR_NUL || c == CHAR_CR || c == CHAR_LF);
        return c;
    endfunction

    // One transfer on the input side, after a random gap.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = src_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (b != CHAR_NUL && b != CHAR_CR)
            items_sent++;
    endtask

    // Random characters with the odd NUL or carriage return mixed in.
    task automatic send_chars(input int n);
        int i;
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                send_byte($urandom_range(0, 1) ? CHAR_NUL : CHAR_CR);
            send_byte(pick_char());
        end
    endtask

    // The four-character sync prefix, with one letter changed if asked.
    task automatic send_prefix(input int flip_pos);
        int p;
        for (p = 0; p < 4; p++)
            send_byte(p == flip_pos ? sync_head[p] ^ 8'h20 : sync_head[p]);
    endtask

    // Stops offering, waits for every owed result, then lets the block settle.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic set_line_limit(input logic [CFG_W-1:0] v);
        wait_for_results();
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        room = (v > LINE_MAX_DEF) ? LINE_MAX_DEF : int'(v);
    endtask

    // One random line, mostly well formed, sized around the current limit.
    task automatic send_random_line();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
        begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            return;
        end
        if (pick < 15)
        begin
            if ($urandom_range(0, 1))
                send_byte(CHAR_CR);
        end
        else if (pick < 30)
        begin
            send_prefix(-1);
            send_chars(2);
        end
        else if (pick < 40)
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    send_prefix(-1);
                    send_chars(1);
                end
                1:
                begin
                    send_prefix(-1);
                    send_chars(3);
                end
                default:
                begin
                    send_prefix($urandom_range(0, 3));
                    send_chars(2);
                end
            endcase
        end
        else if (pick < 50)
            send_chars(room + 1 + $urandom_range(0, 3));
        else if (pick < 58)
            send_chars(room);
        else
            send_chars($urandom_range(1, (room < 1) ? 1 : ((room > 8) ? 8 : room)));
        send_byte(CHAR_LF);
    endtask

    initial
    begin
        logic [CFG_W-1:0] limits [10];
        int               ph;
        int               target;

        limits = '{6'd0, 6'd1, 6'd6, 6'd63, 6'd33, 6'd32, 6'd5, 6'd7,
                   CFG_W'($urandom_range(2, 31)), CFG_W'($urandom_range(0, 63))};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines at the reset limit: empty lines, one with ignored
        // bytes, a sync line, extreme byte values and a short near-sync line.
        src_idle = 1'b0;
        send_byte(CHAR_LF);
        send_byte(CHAR_NUL);
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        send_prefix(-1);
        send_byte(CHAR_NUL);
        send_byte(8'h61);
        send_byte(8'h7A);
        send_byte(CHAR_LF);
        src_idle = 1'b1;
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(CHAR_LF);
        send_prefix(-1);
        send_byte(8'h78);
        send_byte(CHAR_LF);

        // Limit of zero: the first character already overflows.
        set_line_limit(6'd0);
        send_byte(8'h51);
        send_byte(CHAR_LF);
        send_byte(CHAR_LF);

        // Random phases over a spread of limits; one phase never idles.
        for (ph = 0; ph < 10; ph++)
        begin
            set_line_limit(limits[ph]);
            src_idle  = (ph == 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
            sink_idle <= (ph == 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
            target = items_sent + ITEMS_PHASE;
            while (items_sent < target)
                send_random_line();
        end

        // Output stalled for a long stretch while complete lines keep coming,
        // so the block fills up and holds off its input.
        set_line_limit(6'd8);
        src_idle  = 1'b1;
        sink_idle <= 1'b1;
        -> hold_go;
        repeat (6)
        begin
            send_chars(3);
            send_byte(CHAR_LF);
        end

        // A long overflowing line sent back to back.
        set_line_limit(6'd1);
        src_idle = 1'b0;
        send_byte(8'h41);
        repeat (10) send_byte(pick_char());
        send_byte(CHAR_LF);
        send_prefix(-1);
        send_byte(CHAR_LF);

        wait_for_results();
        if (errors == 0)
            $display("** serial_command_line_framer: PASSED **");
        else
            $display("** serial_command_line_framer: FAILED **");
        $finish;
    end

endmodule
